[design/assert_macros.svh]
// Assertion macros for the checker module of the run/delta decoder.
// The macros expect a signal named clk, and all but RGBRD_ASSERT_ALWAYS one named rst, in the scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is high.
`define RGBRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbrd assertion failed");

// Implication checked in the cycle after the antecedent, ignored while reset is high.
`define RGBRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbrd assertion failed");

// Property that must also hold across reset.
`define RGBRD_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rgbrd assertion failed");

`endif

[design/rgbrd_pkg.sv]
// Package for the RGB565 run/delta image decoder: field widths, token and
// delta constants, and the delta bit scatter function. No dependencies.
package rgbrd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned COLOR_W         = 16;
  localparam int unsigned RUN_W           = 16;
  localparam int unsigned OUT_INDEX_W     = 24;
  localparam int unsigned PIX_CNT_W       = 24;
  localparam int unsigned PIXEL_INDEX_DEF = 24;

  localparam logic [BYTE_W-1:0]  TOKEN_LITERAL    = 8'h20;
  localparam logic [COLOR_W-1:0] DELTA_RED_MASK   = 16'h1800;
  localparam logic [COLOR_W-1:0] DELTA_GREEN_MASK = 16'h00e3;
  localparam logic [COLOR_W-1:0] DELTA_BLUE_MASK  = 16'h0003;
  localparam logic [PIX_CNT_W-1:0] PIX_CNT_RESET  = 24'd1;

  // Scatter a delta byte onto colour bits 0-1, 5-7 and 11-12.
  function automatic logic [COLOR_W-1:0] delta_word(input logic [BYTE_W-1:0] b);
    logic [COLOR_W-1:0] w;
    begin
      w = COLOR_W'(b);
      return ((w << 5) & DELTA_RED_MASK) | ((w << 3) & DELTA_GREEN_MASK)
           | (w & DELTA_BLUE_MASK);
    end
  endfunction

endpackage

[design/rgb565_run_delta_image_decoder_top.sv]
// Top level of the RGB565 run/delta image decoder.
// Depends on rgbrd_pkg for widths, constants and the delta scatter function.
//
// Takes one compressed byte per cycle on the s_ side and gives at most one
// pixel run per byte on the m_ side. Every byte is parsed in the cycle it is
// accepted and its run, if any, lands in the output register on that edge, so
// the sustained rate is one byte per clock; the only stall is a full output
// register that the sink does not take. A byte with tuser set clears the
// decoder before it is parsed and starts a new image. pixel_count is written
// through cfg_*; the user must do so only while the decoder is idle, as the block
// does not enforce it. Runs are cut at that count and the run that reaches it
// carries tlast, after which bytes are dropped until the next tuser byte.
module rgb565_run_delta_image_decoder_top #(
  parameter int unsigned PIXEL_INDEX_BITS = rgbrd_pkg::PIXEL_INDEX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,    // pixel_count
  // compressed input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // data_byte
  input  logic        s_tuser,     // first_byte
  // pixel runs
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,     // pixel_color[15:0], run_length[31:16], start_index[55:32]
  output logic        m_tlast      // image_end
);

  localparam int unsigned CW = (PIXEL_INDEX_BITS > rgbrd_pkg::PIX_CNT_W) ?
                               PIXEL_INDEX_BITS : rgbrd_pkg::PIX_CNT_W;

  typedef enum logic [1:0] {
    PH_TOKEN   = 2'd0,
    PH_LIT_HI  = 2'd1,
    PH_CNT_HI  = 2'd2,
    PH_CNT_LO  = 2'd3
  } phase_t;

  // decoder state
  phase_t                             phase, phase_next;
  logic [rgbrd_pkg::BYTE_W-1:0]       held_low, held_low_next;
  logic [rgbrd_pkg::BYTE_W-1:0]       held_cnt_hi, held_cnt_hi_next;
  logic [rgbrd_pkg::COLOR_W-1:0]      ref_color, ref_color_next;
  logic [rgbrd_pkg::COLOR_W-1:0]      last_color, last_color_next;
  logic [PIXEL_INDEX_BITS-1:0]        emitted, emitted_next;
  logic                               finished, finished_next;
  logic [rgbrd_pkg::PIX_CNT_W-1:0]    pixel_count;

  // output register
  logic                               out_valid;
  logic [rgbrd_pkg::COLOR_W-1:0]      out_color;
  logic [rgbrd_pkg::RUN_W-1:0]        out_len;
  logic [rgbrd_pkg::OUT_INDEX_W-1:0]  out_start;
  logic                               out_end;

  // per-byte decode
  logic                               s_acc;
  phase_t                             cur_phase;
  logic [rgbrd_pkg::BYTE_W-1:0]       cur_low, cur_cnt_hi;
  logic [rgbrd_pkg::COLOR_W-1:0]      cur_ref, cur_last;
  logic [PIXEL_INDEX_BITS-1:0]        cur_emitted;
  logic                               cur_finished;
  logic                               emit;
  logic [rgbrd_pkg::COLOR_W-1:0]      run_color, lit_word;
  logic [rgbrd_pkg::RUN_W-1:0]        run_cnt, run_len;
  logic                               run_end;
  logic [CW-1:0]                      start_ext, total_ext, rem;

  assign s_acc     = s_tvalid && s_tready;
  assign s_tready  = !out_valid || m_tready;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_start, out_len, out_color};
  assign m_tlast  = out_end;

  // first_byte clears the decoder before the byte is parsed
  always_comb begin
    if (s_tuser) begin
      cur_phase    = PH_TOKEN;
      cur_low      = '0;
      cur_cnt_hi   = '0;
      cur_ref      = '0;
      cur_last     = '0;
      cur_emitted  = '0;
      cur_finished = 1'b0;
    end else begin
      cur_phase    = phase;
      cur_low      = held_low;
      cur_cnt_hi   = held_cnt_hi;
      cur_ref      = ref_color;
      cur_last     = last_color;
      cur_emitted  = emitted;
      cur_finished = finished;
    end
  end

  // token parse
  always_comb begin
    phase_next       = cur_phase;
    held_low_next    = cur_low;
    held_cnt_hi_next = cur_cnt_hi;
    ref_color_next   = cur_ref;
    last_color_next  = cur_last;
    emit             = 1'b0;
    run_color        = cur_last;
    run_cnt          = rgbrd_pkg::RUN_W'(1);
    lit_word         = {s_tdata, cur_low};
    if (!cur_finished) begin
      unique case (cur_phase)
        PH_TOKEN: begin
          if ((s_tdata & rgbrd_pkg::TOKEN_LITERAL) != '0) begin
            held_low_next = s_tdata;
            phase_next    = PH_LIT_HI;
          end else begin
            last_color_next = cur_ref ^ rgbrd_pkg::delta_word(s_tdata);
            run_color       = last_color_next;
            emit            = 1'b1;
          end
        end
        PH_LIT_HI: begin
          if (lit_word != cur_ref) begin
            ref_color_next  = lit_word;
            last_color_next = lit_word;
            run_color       = lit_word;
            phase_next      = PH_TOKEN;
            emit            = 1'b1;
          end else begin
            phase_next = PH_CNT_HI;
          end
        end
        PH_CNT_HI: begin
          held_cnt_hi_next = s_tdata;
          phase_next       = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          phase_next = PH_TOKEN;
          run_cnt    = {cur_cnt_hi, s_tdata};
          emit       = (run_cnt != '0);
        end
        default: phase_next = PH_TOKEN;
      endcase
    end
  end

  // cut the run at the image end
  always_comb begin
    start_ext = CW'(cur_emitted);
    total_ext = CW'(pixel_count);
    rem       = total_ext - start_ext;
    if (total_ext <= start_ext) begin
      run_len = rgbrd_pkg::RUN_W'(1);
      run_end = 1'b1;
    end else if (CW'(run_cnt) >= rem) begin
      run_len = rem[rgbrd_pkg::RUN_W-1:0];
      run_end = 1'b1;
    end else begin
      run_len = run_cnt;
      run_end = 1'b0;
    end
    emitted_next  = cur_emitted;
    finished_next = cur_finished;
    if (emit) begin
      emitted_next  = PIXEL_INDEX_BITS'(start_ext + CW'(run_len));
      finished_next = run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TOKEN;
      held_low    <= '0;
      held_cnt_hi <= '0;
      ref_color   <= '0;
      last_color  <= '0;
      emitted     <= '0;
      finished    <= 1'b0;
      pixel_count <= rgbrd_pkg::PIX_CNT_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_count <= cfg_data;
      end
      if (s_acc) begin
        phase       <= phase_next;
        held_low    <= held_low_next;
        held_cnt_hi <= held_cnt_hi_next;
        ref_color   <= ref_color_next;
        last_color  <= last_color_next;
        emitted     <= emitted_next;
        finished    <= finished_next;
      end
      if (s_acc && emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (s_acc && emit) begin
      out_color <= run_color;
      out_len   <= run_len;
      out_start <= start_ext[rgbrd_pkg::OUT_INDEX_W-1:0];
      out_end   <= run_end;
    end
  end

endmodule

[design/rgbrd_chk.sv]
// Port-level checker for the RGB565 run/delta image decoder, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rgbrd_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  // a stalled word holds
  `RGBRD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // every run covers at least one pixel
  `RGBRD_ASSERT_IMP(a_len_nz, m_tvalid, m_tdata[31:16] != 16'd0)

  // an empty output register never blocks the input
  `RGBRD_ASSERT_IMP(a_ready_empty, !m_tvalid, s_tready)

  // nothing is offered right after reset
  `RGBRD_ASSERT_ALWAYS(a_rst_empty, rst, !m_tvalid)

endmodule

bind rgb565_run_delta_image_decoder_top rgbrd_chk u_rgbrd_chk (.*);

[tb/testbench.sv]
// Self-checking testbench for the RGB565 run/delta image decoder top level.
// Uses rgbrd_pkg for widths and the literal token bit; needs only the RTL.
// Directed table first, then random images under three stall mixes.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [rgbrd_pkg::COLOR_W-1:0]     color;
    logic [rgbrd_pkg::RUN_W-1:0]       len;
    logic [rgbrd_pkg::OUT_INDEX_W-1:0] start;
    logic                              last;
  } run_t;

  typedef enum logic [1:0] {PH_TOKEN, PH_LIT_HI, PH_CNT_HI, PH_CNT_LO} parse_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [rgbrd_pkg::BYTE_W-1:0]    data;
    logic                            first;
    logic [rgbrd_pkg::PIX_CNT_W-1:0] cfg_value;
    logic                            fixed;   // run below is typed in, not predicted
    run_t                            want;
  } dir_row_t;

  localparam run_t NO_RUN = '0;
  localparam int N_DIR = 23;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int DRAIN_CYCLES = 4;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reset pixel count of one: first delta ends the image
    '{ROW_BYTE, 8'h00, 1'b1, 24'd0, 1'b1, '{16'h0000, 16'd1, 24'd0, 1'b1}},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN},   // dropped after image end
    '{ROW_CFG,  8'h00, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hDF, 1'b1, 24'd0, 1'b0, NO_RUN},
    '{ROW_CFG,  8'h00, 1'b0, 24'hFFFFFF, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h21, 1'b1, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h00, 1'b0, 24'd0, 1'b1, '{16'h0021, 16'd1, 24'd0, 1'b0}},
    // equal literal, count of zero
    '{ROW_BYTE, 8'h21, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h00, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h00, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h00, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hDF, 1'b0, 24'd0, 1'b0, NO_RUN},
    // max repeat of the delta colour
    '{ROW_BYTE, 8'h21, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h00, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN},
    // count lowered below pixels already out
    '{ROW_CFG,  8'h00, 1'b0, 24'd2, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h1F, 1'b0, 24'd0, 1'b0, NO_RUN},
    // new image in the middle of a literal
    '{ROW_BYTE, 8'h3F, 1'b1, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'h12, 1'b1, 24'd0, 1'b0, NO_RUN},
    '{ROW_BYTE, 8'hFF, 1'b0, 24'd0, 1'b0, NO_RUN}
  };

  localparam logic [rgbrd_pkg::PIX_CNT_W-1:0] PHASE_PIX [N_PHASES] = '{
    24'd1, 24'hFFFFFF, 24'd64, 24'd0, 24'd200, 24'hFFFFFF, 24'd25, 24'd1000, 24'd7
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  rgb565_run_delta_image_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // decoder state as the testbench sees it
  logic [rgbrd_pkg::PIX_CNT_W-1:0] pix_count;
  parse_t                          parse_st;
  logic [7:0]                      lo_byte;
  logic [7:0]                      cnt_hi;
  logic [rgbrd_pkg::COLOR_W-1:0]   ref_color;
  logic [rgbrd_pkg::COLOR_W-1:0]   last_color;
  logic [23:0]                     emitted;
  logic                            img_done;

  run_t runs_due [$];
  run_t head_run;
  int   src_idle_pct = 27;
  int   snk_idle_pct = 78;
  int   errors = 0;
  int   bytes_decoded = 0;
  int   runs_checked = 0;
  int   images = 0;
  logic pending_first = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void clear_decoder();
    parse_st   = PH_TOKEN;
    lo_byte    = '0;
    cnt_hi     = '0;
    ref_color  = '0;
    last_color = '0;
    emitted    = '0;
    img_done   = 1'b0;
  endfunction

  // Cut a run at the image end and advance the pixel counter.
  function automatic run_t make_run(input logic [15:0] color, input logic [15:0] count);
    run_t        r;
    logic [23:0] rem;
    r.color = color;
    r.start = emitted;
    if (pix_count <= emitted) begin
      r.len  = 16'd1;
      r.last = 1'b1;
    end else begin
      rem = pix_count - emitted;
      if ({8'd0, count} >= rem) begin
        r.len  = rem[15:0];
        r.last = 1'b1;
      end else begin
        r.len  = count;
        r.last = 1'b0;
      end
    end
    emitted = emitted + {8'd0, r.len};
    if (r.last) img_done = 1'b1;
    return r;
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, input logic first,
                                      output run_t run, output bit skipped);
    logic [15:0] word;
    run     = NO_RUN;
    skipped = 1'b0;
    if (first) clear_decoder();
    if (img_done) begin
      skipped = 1'b1;
      return 1'b0;
    end
    case (parse_st)
      PH_TOKEN: begin
        if ((b & rgbrd_pkg::TOKEN_LITERAL) != 0) begin
          lo_byte  = b;
          parse_st = PH_LIT_HI;
          return 1'b0;
        end
        // delta bits land on colour bits 0-1, 5-7, 11-12
        last_color = ref_color ^ {3'b000, b[7:6], 3'b000, b[4:2], 3'b000, b[1:0]};
        run = make_run(last_color, 16'd1);
        return 1'b1;
      end
      PH_LIT_HI: begin
        word = {b, lo_byte};
        if (word != ref_color) begin
          ref_color  = word;
          last_color = word;
          parse_st   = PH_TOKEN;
          run = make_run(word, 16'd1);
          return 1'b1;
        end
        parse_st = PH_CNT_HI;
        return 1'b0;
      end
      PH_CNT_HI: begin
        cnt_hi   = b;
        parse_st = PH_CNT_LO;
        return 1'b0;
      end
      default: begin
        parse_st = PH_TOKEN;
        word = {cnt_hi, b};
        if (word == 16'd0) return 1'b0;
        run = make_run(last_color, word);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic fixed,
                           input run_t want);
    run_t run;
    logic f;
    bit   got;
    bit   skipped;
    f = first | pending_first;
    pending_first = 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= f;
    do @(posedge clk); while (s_tready !== 1'b1);
    if (f) images++;
    got = predict_byte(b, f, run, skipped);
    if (!skipped) bytes_decoded++;
    if (fixed) runs_due.push_back(want);
    else if (got) runs_due.push_back(run);
  endtask

  // Drop valid, let every pending run drain, then let the parser idle before going on.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (runs_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    pix_count = value;
  endtask

  // One random token: mostly well formed, some noise and cut-off repeats.
  task automatic send_token();
    logic [15:0] cnt;
    logic [15:0] rc;
    int          pick;
    pick = $urandom_range(99);
    rc   = ref_color;
    case ($urandom_range(9))
      0:       cnt = 16'd0;
      1:       cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(1, 30));
    endcase
    if (pick < 8) begin
      send_byte(8'($urandom), $urandom_range(15) == 0, 1'b0, NO_RUN);
    end else if (pick < 40) begin
      send_byte(8'($urandom) & ~rgbrd_pkg::TOKEN_LITERAL, 1'b0, 1'b0, NO_RUN);
    end else if (pick < 60 || !rc[5] || pending_first) begin
      send_byte(8'($urandom) | rgbrd_pkg::TOKEN_LITERAL, 1'b0, 1'b0, NO_RUN);
      send_byte(8'($urandom), 1'b0, 1'b0, NO_RUN);
    end else begin
      send_byte(rc[7:0], 1'b0, 1'b0, NO_RUN);
      send_byte(rc[15:8], 1'b0, 1'b0, NO_RUN);
      // otherwise the next token's bytes get read as the count
      if (pick < 96) begin
        send_byte(cnt[15:8], 1'b0, 1'b0, NO_RUN);
        send_byte(cnt[7:0], 1'b0, 1'b0, NO_RUN);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (runs_due.size() == 0) begin
        $error("run word with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
        errors++;
      end else begin
        head_run = runs_due.pop_front();
        runs_checked++;
        if (m_tdata[15:0] !== head_run.color) begin
          $error("pixel_color: expected %h, got %h", head_run.color, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== head_run.len) begin
          $error("run_length: expected %0d, got %0d", head_run.len, m_tdata[31:16]);
          errors++;
        end
        if (m_tdata[55:32] !== head_run.start) begin
          $error("start_index: expected %0d, got %0d", head_run.start, m_tdata[55:32]);
          errors++;
        end
        if (m_tlast !== head_run.last) begin
          $error("image_end: expected %b, got %b", head_run.last, m_tlast);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    int target;
    int p;
    pix_count = rgbrd_pkg::PIX_CNT_RESET;
    clear_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        settle();
        write_cfg(DIR_ROWS[i].cfg_value);
      end else begin
        send_byte(DIR_ROWS[i].data, DIR_ROWS[i].first, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      settle();
      case (p / 3)
        0: begin
          src_idle_pct = 27;
          snk_idle_pct = 78;
        end
        1: begin
          src_idle_pct = 78;
          snk_idle_pct = 27;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_cfg(PHASE_PIX[p]);
      pending_first = 1'b1;
      target = bytes_decoded + ITEMS_PER_PHASE;
      while (bytes_decoded < target) begin
        // after image end, usually start the next one; rarely restart mid-image
        if (img_done ? ($urandom_range(99) < 85) : ($urandom_range(299) == 0))
          pending_first = 1'b1;
        send_token();
      end
    end
    settle();

    $display("summary: %0d bytes decoded into %0d runs over %0d images", bytes_decoded,
             runs_checked, images);
    $display("summary: pixel counts 0 to 16777215, source and sink stalls swapped, then none");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rgbrd_pkg.sv
design/rgb565_run_delta_image_decoder_top.sv
design/rgbrd_chk.sv
tb/testbench.sv
